### design/business_day_counter_top_assert.svh
// Assertion macros for the business day counter
`ifndef BUSINESS_DAY_COUNTER_TOP_ASSERT_SVH
`define BUSINESS_DAY_COUNTER_TOP_ASSERT_SVH
// An error result always carries a zero count
`define BDC_ERR_ZERO(lbl, vld, err, cnt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && (err)) |-> ((cnt) == '0)) else $error("error beat with nonzero count");
// A stalled output stage keeps its valid bit
`define BDC_HOLD(lbl, vld, stl) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && (stl)) |=> (vld)) else $error("stage lost a beat under stall");
`endif

### design/bdc_pkg.sv
`default_nettype none
package bdc_pkg;
	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
	} in_t;

	typedef struct packed {
		logic [15:0] business_days;
		logic        date_error;
	} out_t;

	localparam logic [8:0] YEAR_SHIFT = 9'd400;
	localparam logic [3:0] FRIDAY = 4'd5;

	// Reciprocals: divide by 100 with a shift of 19, by 7 with a shift of 26
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [23:0] RECIP_7 = 24'd9586981;

	// Days before each month, year starting in March
	function automatic logic [8:0] month_off(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd3: r = 9'd0;
			4'd4: r = 9'd31;
			4'd5: r = 9'd61;
			4'd6: r = 9'd92;
			4'd7: r = 9'd122;
			4'd8: r = 9'd153;
			4'd9: r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			4'd12: r = 9'd275;
			4'd1: r = 9'd306;
			default: r = 9'd337;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### design/business_day_counter_top.sv
// Business day counter: counts dates in [start, end) that are not Friday or
// Saturday. Six-stage pipeline (year split, validity and century terms, day
// numbers, span and start weekday, weeks and leftover days, final count); one
// beat can enter every cycle while in_stall is low, and out_valid rises when
// the beat reaches the final count stage. A stalled result holds the whole
// pipeline, so in_stall follows out_stall while the last stage holds a beat,
// and every beat in flight waits in its stage during a stall. Invalid dates
// give date_error and zero.
`default_nettype none
`include "business_day_counter_top_assert.svh"
module business_day_counter_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire bdc_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_stall,
	output bdc_pkg::out_t     out_data
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;
	assign adv = !(v_s6 && out_stall);
	assign in_stall = !adv;

	// Stage 1: shifted years, quotients of the years by 100
	logic [14:0] sya_s1, eya_s1;
	logic [13:0] sy_s1, ey_s1;
	logic [7:0]  syq_s1, eyq_s1;
	logic [3:0]  sm_s1, em_s1;
	logic [4:0]  sd_s1, ed_s1;
	logic [14:0] sya, eya;
	logic [26:0] syq_full, eyq_full;
	always_comb begin
		sya = {1'b0, in_data.start_year} + 15'(bdc_pkg::YEAR_SHIFT)
			- 15'(in_data.start_month <= 4'd2);
		eya = {1'b0, in_data.end_year} + 15'(bdc_pkg::YEAR_SHIFT)
			- 15'(in_data.end_month <= 4'd2);
		// divide by 100 as a multiply by 5243 / 2^19, exact for these widths
		syq_full = 27'(in_data.start_year) * 27'(bdc_pkg::RECIP_100);
		eyq_full = 27'(in_data.end_year) * 27'(bdc_pkg::RECIP_100);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sya_s1 <= sya; eya_s1 <= eya;
			sy_s1 <= in_data.start_year; ey_s1 <= in_data.end_year;
			syq_s1 <= syq_full[26:19]; eyq_s1 <= eyq_full[26:19];
			sm_s1 <= in_data.start_month; em_s1 <= in_data.end_month;
			sd_s1 <= in_data.start_day; ed_s1 <= in_data.end_day;
		end
	end

	// Stage 2: validity and leap-day corrections per date
	logic [14:0] sya_s2, eya_s2;
	logic [12:0] scor_s2, ecor_s2;
	logic [8:0]  soff_s2, eoff_s2;
	logic [4:0]  sd_s2, ed_s2;
	logic        err_s2;
	logic        sleap, eleap, sok, eok;
	logic [27:0] saq_full, eaq_full;
	logic [8:0]  saq, eaq;
	always_comb begin
		// a century year is leap only when its century count is a multiple of four
		sleap = (sy_s1 == {6'd0, syq_s1} * 14'd100) ? (syq_s1[1:0] == 2'd0)
			: (sy_s1[1:0] == 2'd0);
		eleap = (ey_s1 == {6'd0, eyq_s1} * 14'd100) ? (eyq_s1[1:0] == 2'd0)
			: (ey_s1[1:0] == 2'd0);
		sok = sm_s1 >= 4'd1 && sm_s1 <= 4'd12 && sd_s1 >= 5'd1 &&
			sd_s1 <= bdc_pkg::month_len(sm_s1, sleap);
		eok = em_s1 >= 4'd1 && em_s1 <= 4'd12 && ed_s1 >= 5'd1 &&
			ed_s1 <= bdc_pkg::month_len(em_s1, eleap);
		saq_full = 28'(sya_s1) * 28'(bdc_pkg::RECIP_100);
		eaq_full = 28'(eya_s1) * 28'(bdc_pkg::RECIP_100);
		saq = saq_full[27:19];
		eaq = eaq_full[27:19];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sya_s2 <= sya_s1; eya_s2 <= eya_s1;
			scor_s2 <= sya_s1[14:2] - {4'd0, saq} + {6'd0, saq[8:2]};
			ecor_s2 <= eya_s1[14:2] - {4'd0, eaq} + {6'd0, eaq[8:2]};
			soff_s2 <= bdc_pkg::month_off(sm_s1); eoff_s2 <= bdc_pkg::month_off(em_s1);
			sd_s2 <= sd_s1; ed_s2 <= ed_s1;
			err_s2 <= !(sok && eok);
		end
	end

	// Stage 3: serial day numbers
	logic [22:0] sser_s3, eser_s3;
	logic        err_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sser_s3 <= 23'(sya_s2) * 23'd365 + 23'(scor_s2) + 23'(soff_s2) + 23'(sd_s2);
			eser_s3 <= 23'(eya_s2) * 23'd365 + 23'(ecor_s2) + 23'(eoff_s2) + 23'(ed_s2);
			err_s3 <= err_s2;
		end
	end

	// Stage 4: span and start weekday (serial 0 mod 7 falls on a Tuesday)
	logic [22:0] n_s4;
	logic [2:0]  w_s4;
	logic        pos_s4, err_s4;
	logic [22:0] wx;
	logic [46:0] wq_full;
	logic [20:0] wq;
	always_comb begin
		// reduce mod 7 by a multiply with ceil(2^26 / 7), exact below 2^23
		wx = sser_s3 + 23'd2;
		wq_full = 47'(wx) * 47'(bdc_pkg::RECIP_7);
		wq = wq_full[46:26];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4 <= eser_s3 - sser_s3;
			pos_s4 <= sser_s3 < eser_s3;
			w_s4 <= 3'(wx - 23'(wq) * 23'd7);
			err_s4 <= err_s3;
		end
	end

	// Stage 5: split the span into whole weeks and leftover days
	logic [20:0] weeks_s5;
	logic [2:0]  rem_s5, w_s5;
	logic        pos_s5, err_s5;
	logic [46:0] nq_full;
	logic [20:0] nq;
	always_comb begin
		nq_full = 47'(n_s4) * 47'(bdc_pkg::RECIP_7);
		nq = nq_full[46:26];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			weeks_s5 <= nq;
			rem_s5 <= 3'(n_s4 - 23'(nq) * 23'd7);
			w_s5 <= w_s4;
			pos_s5 <= pos_s4;
			err_s5 <= err_s4;
		end
	end

	// Stage 6: whole weeks times five plus the leftover walk, saturate; zero on error or empty span
	logic [2:0]  extra;
	logic [3:0]  wd;
	logic [23:0] cnt;
	always_comb begin
		extra = '0;
		wd = '0;
		for (int i = 0; i < 6; i++) begin
			wd = {1'b0, w_s5} + 4'(i);
			if (wd >= 4'd7) wd = wd - 4'd7;
			if (3'(i) < rem_s5 && wd < bdc_pkg::FRIDAY) extra = extra + 3'd1;
		end
		cnt = 24'(weeks_s5) * 24'd5 + 24'(extra);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.date_error <= err_s5;
			if (err_s5 || !pos_s5) out_data.business_days <= '0;
			else if (cnt > 24'd65535) out_data.business_days <= 16'hFFFF;
			else out_data.business_days <= cnt[15:0];
		end
	end
	assign out_valid = v_s6;

	`BDC_ERR_ZERO(a_err_zero, out_valid, out_data.date_error, out_data.business_days)
	`BDC_HOLD(a_out_hold, out_valid, out_stall)
endmodule
`default_nettype wire
